/* rtl/pnc_pkg.sv */
// shared types and constants for the nearest palette colour search
// no dependencies; imported by every module of the block
package pnc_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  localparam int IDX_W    = 8;
  localparam int CH_W     = 8;
  localparam int COLOUR_W = 3 * CH_W;
  localparam int SQ_W     = 2 * CH_W;
  localparam int DIST_W   = SQ_W + 2;

  // highest usable palette index, as an index-wide value
  localparam logic [IDX_W-1:0] PAL_TOP = IDX_W'(PALETTE_ENTRIES - 1);

  // running minimum starts at all ones
  localparam logic [DIST_W-1:0] DIST_MAX = ~'0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [COLOUR_W-1:0] colour_t;

  // tag that travels with one palette entry through the scan pipeline
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] index;
  } scan_tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

endpackage

/* rtl/pnc_palette_ram.sv */
// palette storage: one write port, one registered read port
// depends on pnc_pkg for depth and entry type
module pnc_palette_ram
  import pnc_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [PAL_AW-1:0] wr_addr,
  input  colour_t           wr_data,
  input  logic [PAL_AW-1:0] rd_addr,
  output colour_t           rd_data
);

  colour_t mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/pnc_dist_unit.sv */
// shared squared euclidean distance unit, one registered stage
// depends on pnc_pkg for colour, distance and tag types
module pnc_dist_unit
  import pnc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              flush,
  input  scan_tag_t         tag_in,
  input  colour_t           entry,
  input  colour_t           query,
  output scan_tag_t         tag_out,
  output logic [DIST_W-1:0] dist_out
);

  function automatic logic [SQ_W-1:0] chan_sq(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  logic [SQ_W-1:0]   sq_red, sq_green, sq_blue;
  logic [DIST_W-1:0] dist_nxt;

  always_comb begin
    sq_red   = chan_sq(entry[3*CH_W-1:2*CH_W], query[3*CH_W-1:2*CH_W]);
    sq_green = chan_sq(entry[2*CH_W-1:CH_W],   query[2*CH_W-1:CH_W]);
    sq_blue  = chan_sq(entry[CH_W-1:0],        query[CH_W-1:0]);
    dist_nxt = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_out <= '0;
    end else if (flush) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    dist_out <= dist_nxt;
  end

endmodule

/* rtl/palette_nearest_color_search.sv */
// top level of the nearest palette colour search
// depends on pnc_pkg, pnc_palette_ram and pnc_dist_unit
//
// A write item (opcode 0) stores one 24-bit palette entry and gives no result.
// A query item (opcode 1) walks the inclusive index range one palette entry
// per cycle through the single palette read port and the single shared
// distance unit, keeping the lowest index of smallest squared distance and
// stopping at the first exact match. Each entry that a query looks at passes
// the read, distance and compare stages, and the result step then loads the
// output register; an empty range goes straight to the result step and gives
// index 0. Worst case is a full 256-entry scan, and the next item is taken
// only once the sequencer is back in idle. in_ready is high only while the
// sequencer is idle; a finished result sits in the output register until it
// is taken, and the sequencer waits in its result step only when that
// register is still full. Every entry read by a query must have been written.
module palette_nearest_color_search
  import pnc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_opcode,
  input  logic [IDX_W-1:0] in_entry_index,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  input  logic [IDX_W-1:0] in_range_first,
  input  logic [IDX_W-1:0] in_range_last,

  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_nearest_index
);

  // sequencer state
  state_t state_r, state_nxt;

  // scan address generator
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] scan_last_r;
  logic             issue_on_r;
  logic             issue_last;

  // pipeline tags: read stage and distance stage
  scan_tag_t        tag1_r;
  scan_tag_t        tag2;
  logic [DIST_W-1:0] cur_dist;

  // running search result
  logic [IDX_W-1:0]  best_r;
  logic [DIST_W-1:0] smallest_r;
  colour_t           query_r;

  // output register
  logic             out_valid_r;
  logic [IDX_W-1:0] out_nearest_index_r;

  // handshake and decode
  logic             in_xfer;
  logic             query_xfer;
  logic             write_en;
  logic [IDX_W-1:0] last_clamped;
  logic             range_empty;

  // control from the output decoder
  logic             cand;
  logic             scan_done;
  logic             out_load;

  colour_t          rd_entry;

  assign in_xfer    = in_valid && in_ready;
  assign query_xfer = in_xfer && (in_opcode == OP_QUERY);

  // writes beyond the palette are dropped
  assign write_en = in_xfer && (in_opcode == OP_WRITE) &&
                    ({1'b0, in_entry_index} < (IDX_W + 1)'(PALETTE_ENTRIES));

  // range end clamped to the palette, then emptiness check
  assign last_clamped = (in_range_last > PAL_TOP) ? PAL_TOP : in_range_last;
  assign range_empty  = in_range_first > last_clamped;

  assign issue_last = (scan_idx_r == scan_last_r);

  pnc_palette_ram u_ram (
    .clk     (clk),
    .wr_en   (write_en),
    .wr_addr (in_entry_index[PAL_AW-1:0]),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_addr (scan_idx_r[PAL_AW-1:0]),
    .rd_data (rd_entry)
  );

  pnc_dist_unit u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (scan_done),
    .tag_in   (tag1_r),
    .entry    (rd_entry),
    .query    (query_r),
    .tag_out  (tag2),
    .dist_out (cur_dist)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (query_xfer) begin
          state_nxt = range_empty ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    cand      = 1'b0;
    scan_done = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        // strictly smaller keeps the lower index on a tie
        cand      = tag2.valid && (cur_dist < smallest_r);
        // exact match ends the scan early
        scan_done = tag2.valid && ((cand && (cur_dist == '0)) || tag2.last);
      end
      ST_RESULT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_on_r  <= 1'b0;
      tag1_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (scan_done) begin
        // entries still in flight behind the finishing one are dropped
        issue_on_r   <= 1'b0;
        tag1_r.valid <= 1'b0;
      end else if (query_xfer) begin
        issue_on_r   <= !range_empty;
        tag1_r.valid <= 1'b0;
      end else if (issue_on_r) begin
        // address generator feeds the read stage one entry per cycle
        tag1_r <= '{valid: 1'b1, last: issue_last, index: scan_idx_r};
        if (issue_last) begin
          issue_on_r <= 1'b0;
        end
      end else begin
        tag1_r.valid <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (query_xfer) begin
      query_r     <= {in_red, in_green, in_blue};
      scan_idx_r  <= in_range_first;
      scan_last_r <= last_clamped;
      best_r      <= '0;
      smallest_r  <= DIST_MAX;
    end else begin
      if (issue_on_r && !issue_last) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (cand) begin
        best_r     <= tag2.index;
        smallest_r <= cur_dist;
      end
    end

    if (out_load) begin
      out_nearest_index_r <= best_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_nearest_index_r;

  // tags in the distance stage only exist while scanning
  a_tag_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    tag2.valid |-> (state_r == ST_SCAN))
    else $error("scan tag valid outside scan");

  // an exact match always ends the scan, so the minimum never reaches zero
  a_min_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (smallest_r != '0))
    else $error("running minimum zero during scan");

  // entries compared never lie beyond the clamped range end
  a_tag_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    tag2.valid |-> (tag2.index <= scan_last_r))
    else $error("scanned index beyond range end");

  // a result appears only from the result step
  a_out_from_result : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result raised outside result step");

endmodule
